// File: design/abnd_pkg.sv
// shared types, codes and constants for the annex b deframer
package abnd_pkg;

	localparam int TAG_WIDTH = 16;
	localparam int TAG_FIFO_DEPTH_DEF = 16;
	localparam int CMD_Q_DEPTH = 4;
	localparam int CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
	localparam int CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

	localparam logic [0:0] OP_STREAM = 1'b0;
	localparam logic [0:0] OP_PUSH   = 1'b1;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_PUSH    = 2'd2;

	localparam logic [1:0] QERR_NONE  = 2'd0;
	localparam logic [1:0] QERR_FULL  = 2'd1;
	localparam logic [1:0] QERR_EMPTY = 2'd2;

	localparam logic [1:0] CMD_BYTES = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_PUSH  = 2'd2;

	localparam logic [7:0] TYPE_MASK = 8'h7e;
	localparam logic [5:0] PIC_LOW_LAST   = 6'd9;
	localparam logic [5:0] PIC_HIGH_FIRST = 6'd16;
	localparam logic [5:0] PIC_HIGH_LAST  = 6'd21;
	localparam logic [1:0] HELD_MAX = 2'd3;
	localparam logic [7:0] START_BYTE = 8'h01;

	typedef struct packed {
		logic [0:0]           operation;
		logic [7:0]           stream_byte;
		logic [TAG_WIDTH-1:0] frame_tag_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           result_kind;
		logic [7:0]           payload_byte;
		logic [31:0]          unit_length;
		logic [5:0]           unit_type;
		logic [TAG_WIDTH-1:0] frame_tag_out;
		logic                 tag_valid;
		logic [1:0]           queue_error;
		logic                 last_of_run;
	} out_item_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic [1:0]           kind;
		logic [1:0]           zeros;
		logic                 has_byte;
		logic [7:0]           data;
		logic [31:0]          length;
		logic [5:0]           utype;
		logic [TAG_WIDTH-1:0] tag;
	} cmd_t;

endpackage

// File: design/abnd_front.sv
// front end: start code scan, unit bookkeeping and request classification
module abnd_front import abnd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     cmd_push,
	output cmd_t     cmd,
	input  logic     cmd_full
);

	logic [1:0]  held_q;
	logic        inside_q;
	logic [31:0] count_q;
	logic [5:0]  type_q;

	logic        accept;
	logic        is_zero;
	logic        is_start;
	logic        emit_bytes;
	logic [2:0]  n_bytes;
	logic [32:0] count_sum;
	logic [7:0]  masked;

	assign item_ready = !cmd_full;
	assign accept     = item_valid && item_ready;
	assign is_zero    = (item.stream_byte == 8'h00);
	assign is_start   = (item.stream_byte == START_BYTE) && (held_q == HELD_MAX);
	assign masked     = item.stream_byte & TYPE_MASK;

	always_comb begin
		cmd          = '0;
		cmd.data     = item.stream_byte;
		cmd.tag      = item.frame_tag_in;
		cmd.length   = count_q;
		cmd.utype    = (count_q == 32'd0) ? 6'd0 : type_q;
		cmd_push     = 1'b0;
		emit_bytes   = 1'b0;
		n_bytes      = 3'd0;
		if (item.operation == OP_PUSH) begin
			cmd.kind = CMD_PUSH;
			cmd_push = accept;
		end else if (is_zero) begin
			// window slides: oldest held zero becomes payload
			if (held_q == HELD_MAX && inside_q) begin
				cmd.kind   = CMD_BYTES;
				cmd.zeros  = 2'd1;
				cmd_push   = accept;
				emit_bytes = 1'b1;
				n_bytes    = 3'd1;
			end
		end else if (is_start) begin
			cmd.kind = CMD_END;
			cmd_push = accept && inside_q;
		end else if (inside_q) begin
			cmd.kind     = CMD_BYTES;
			cmd.zeros    = held_q;
			cmd.has_byte = 1'b1;
			cmd_push     = accept;
			emit_bytes   = 1'b1;
			n_bytes      = {1'b0, held_q} + 3'd1;
		end
	end

	assign count_sum = {1'b0, count_q} + 33'(n_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			inside_q <= 1'b0;
			count_q  <= '0;
			type_q   <= '0;
		end else if (accept && item.operation == OP_STREAM) begin
			if (is_zero) begin
				if (held_q != HELD_MAX) begin
					held_q <= held_q + 2'd1;
				end
			end else if (is_start) begin
				inside_q <= 1'b1;
				count_q  <= '0;
				type_q   <= '0;
				held_q   <= '0;
			end else begin
				held_q <= '0;
			end
			if (emit_bytes) begin
				if (count_q == 32'd0) begin
					// a leading zero makes the type zero
					type_q <= (cmd.zeros != 2'd0 || is_zero) ? 6'd0 : masked[6:1];
				end
				count_q <= count_sum[32] ? 32'hffff_ffff : count_sum[31:0];
			end
		end
	end

endmodule

// File: design/abnd_cmd_queue.sv
// short request queue between front and back
module abnd_cmd_queue import abnd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	output logic head_valid,
	output cmd_t head,
	input  logic pop
);

	cmd_t                   entries_q [CMD_Q_DEPTH];
	logic [CMD_Q_PTR_W-1:0] wr_ptr_q;
	logic [CMD_Q_PTR_W-1:0] rd_ptr_q;
	logic [CMD_Q_CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CMD_Q_CNT_W'(CMD_Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/abnd_back.sv
// back end: result expansion, tag fifo and output register
module abnd_back import abnd_pkg::*; #(
	parameter int TAG_FIFO_DEPTH = TAG_FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	localparam int PTR_W  = $clog2(TAG_FIFO_DEPTH);
	localparam int FILL_W = $clog2(TAG_FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(TAG_FIFO_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TAG_FIFO_DEPTH);

	logic [TAG_WIDTH-1:0] tag_mem [TAG_FIFO_DEPTH];
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [FILL_W-1:0]    fill_q;
	logic [1:0]           idx_q;
	logic                 result_valid_q;
	out_item_t            result_q;
	logic [TAG_WIDTH-1:0] tag_out_q;

	logic      fire;
	logic      last;
	logic      pic;
	logic      do_pop;
	logic      do_push;
	logic [2:0] total;
	out_item_t res_next;

	assign fire  = head_valid && (!result_valid_q || result_ready);
	assign total = {1'b0, head.zeros} + {2'b00, head.has_byte};
	assign pic   = (head.utype <= PIC_LOW_LAST) ||
	               (head.utype >= PIC_HIGH_FIRST && head.utype <= PIC_HIGH_LAST);

	always_comb begin
		res_next = '0;
		last     = 1'b1;
		do_pop   = 1'b0;
		do_push  = 1'b0;
		unique case (head.kind)
			CMD_BYTES: begin
				res_next.result_kind  = KIND_PAYLOAD;
				res_next.payload_byte = ({1'b0, idx_q} < {1'b0, head.zeros}) ? 8'h00 : head.data;
				last = ({1'b0, idx_q} == total - 3'd1);
			end
			CMD_END: begin
				res_next.result_kind = KIND_END;
				res_next.unit_length = head.length;
				res_next.unit_type   = head.utype;
				if (head.length != 32'd0 && pic) begin
					if (fill_q == '0) begin
						res_next.queue_error = QERR_EMPTY;
					end else begin
						res_next.tag_valid = 1'b1;
						do_pop = 1'b1;
					end
				end
			end
			CMD_PUSH: begin
				res_next.result_kind = KIND_PUSH;
				if (fill_q == FILL_MAX) begin
					res_next.queue_error = QERR_FULL;
				end else begin
					do_push = 1'b1;
				end
			end
			default: begin
				res_next = '0;
			end
		endcase
		res_next.last_of_run = last;
	end

	assign pop          = fire && last;
	assign result_valid = result_valid_q;

	always_comb begin
		result               = result_q;
		result.frame_tag_out = tag_out_q;
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			tag_mem[wr_ptr_q] <= head.tag;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q  <= res_next;
			tag_out_q <= do_pop ? tag_mem[rd_ptr_q] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			idx_q          <= '0;
			rd_ptr_q       <= '0;
			wr_ptr_q       <= '0;
			fill_q         <= '0;
		end else begin
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (fire) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			if (fire && do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				fill_q   <= fill_q + 1'b1;
			end
			if (fire && do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				fill_q   <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: design/annexb_nal_deframer_with_tag_fifo_unit.sv
// annex b deframer with frame tag fifo: top level
//
// item channel (valid/ready): operation 0 brings one stream byte, operation 1
// pushes a frame tag. result channel (valid/ready): payload bytes, end-of-unit
// descriptors and tag push status, last_of_run marking the final result of a
// request. bytes before the first start code and held zeros give no result.
// one request is taken per cycle while the four-entry request queue has room;
// the back end emits one result per cycle unless the receiver stalls, so a byte
// that releases held zeros occupies it for up to four results. a request is kept
// in a queue entry and its first result in the output register. when the receiver
// stalls the output register holds its result, the queue fills and item_ready drops
// once it is full. reset clears the scan state, the unit counters and the tag fifo
// pointers; the tag fifo storage itself is not cleared and needs no clearing pass.
module annexb_nal_deframer_with_tag_fifo_unit import abnd_pkg::*; #(
	parameter int TAG_FIFO_DEPTH = TAG_FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic cmd_push;
	cmd_t cmd;
	logic cmd_full;
	logic head_valid;
	cmd_t head;
	logic head_pop;

	abnd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_push   (cmd_push),
		.cmd        (cmd),
		.cmd_full   (cmd_full)
	);

	abnd_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd),
		.full       (cmd_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (head_pop)
	);

	abnd_back #(
		.TAG_FIFO_DEPTH (TAG_FIFO_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (head_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: tb/annexb_nal_deframer_with_tag_fifo_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the annex b deframer with frame tag fifo
module annexb_nal_deframer_with_tag_fifo_unit_test;
	import abnd_pkg::*;

	localparam int TAG_DEPTH = TAG_FIFO_DEPTH_DEF;
	localparam int DIRECTED_ROWS = 28;
	localparam int RANDOM_ITEMS = 382;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		in_item_t  stim;
		logic      known;
		out_item_t want;
	} plan_row_t;

	localparam out_item_t NO_RESULT = '0;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	annexb_nal_deframer_with_tag_fifo_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	plan_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{OP_PUSH, 8'h00, 16'hffff}, 1'b1,
			'{KIND_PUSH, 8'h00, 32'd0, 6'd0, 16'h0000, 1'b0, QERR_NONE, 1'b1}},
		// dropped, no unit open yet
		'{'{OP_STREAM, 8'hff, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, START_BYTE, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h26, 16'h0000}, 1'b0, NO_RESULT},
		// four zeros: the window slides and the oldest one becomes payload
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, START_BYTE, 16'h0000}, 1'b0, NO_RESULT},
		// back-to-back start codes give an empty unit
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, START_BYTE, 16'h0000}, 1'b1,
			'{KIND_END, 8'h00, 32'd0, 6'd0, 16'h0000, 1'b0, QERR_NONE, 1'b1}},
		// non-picture unit, then a byte releasing a held zero
		'{'{OP_STREAM, 8'h40, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h07, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, START_BYTE, 16'h0000}, 1'b0, NO_RESULT},
		// picture unit with the tag fifo already drained
		'{'{OP_STREAM, 8'h02, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, 8'h00, 16'h0000}, 1'b0, NO_RESULT},
		'{'{OP_STREAM, START_BYTE, 16'h0000}, 1'b1,
			'{KIND_END, 8'h00, 32'd1, 6'd1, 16'h0000, 1'b0, QERR_EMPTY, 1'b1}}
	};

	plan_row_t   feed_q[$];
	out_item_t   awaited_q[$];
	out_item_t   step_q[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int unsigned cycles_run = 0;

	// deframer state as the block should hold it
	logic [1:0]  zeros_held = '0;
	logic        in_unit = 1'b0;
	logic [31:0] unit_bytes = '0;
	logic [5:0]  first_type = '0;
	logic [TAG_WIDTH-1:0] tag_store [TAG_DEPTH];
	int          tag_rd = 0;
	int          tag_wr = 0;
	int          tags_held = 0;

	task automatic add_byte(input logic [7:0] b);
		plan_row_t row;
		row = '0;
		row.stim.operation = OP_STREAM;
		row.stim.stream_byte = b;
		row.stim.frame_tag_in = TAG_WIDTH'($urandom);
		feed_q.push_back(row);
	endtask

	task automatic add_tag();
		plan_row_t row;
		row = '0;
		row.stim.operation = OP_PUSH;
		row.stim.stream_byte = 8'($urandom);
		row.stim.frame_tag_in = TAG_WIDTH'($urandom);
		feed_q.push_back(row);
	endtask

	task automatic put_payload(input logic [7:0] b);
		out_item_t r;
		logic [7:0] masked;
		r = '0;
		masked = b & TYPE_MASK;
		if (!in_unit)
			return;
		if (unit_bytes == 32'd0)
			first_type = masked[6:1];
		if (unit_bytes != 32'hffff_ffff)
			unit_bytes = unit_bytes + 32'd1;
		r.result_kind = KIND_PAYLOAD;
		r.payload_byte = b;
		step_q.push_back(r);
	endtask

	task automatic close_unit();
		out_item_t r;
		logic [5:0] t;
		r = '0;
		t = (unit_bytes == 32'd0) ? 6'd0 : first_type;
		r.result_kind = KIND_END;
		r.unit_length = unit_bytes;
		r.unit_type = t;
		if (unit_bytes != 32'd0 &&
				(t <= PIC_LOW_LAST || (t >= PIC_HIGH_FIRST && t <= PIC_HIGH_LAST))) begin
			if (tags_held == 0) begin
				r.queue_error = QERR_EMPTY;
			end else begin
				r.frame_tag_out = tag_store[tag_rd];
				r.tag_valid = 1'b1;
				tag_rd = (tag_rd + 1) % TAG_DEPTH;
				tags_held--;
			end
		end
		step_q.push_back(r);
	endtask

	// fills step_q with the results one accepted request should cause
	task automatic deframe_request(input in_item_t it);
		out_item_t r;
		step_q.delete();
		if (it.operation == OP_PUSH) begin
			r = '0;
			r.result_kind = KIND_PUSH;
			if (tags_held >= TAG_DEPTH) begin
				r.queue_error = QERR_FULL;
			end else begin
				tag_store[tag_wr] = it.frame_tag_in;
				tag_wr = (tag_wr + 1) % TAG_DEPTH;
				tags_held++;
			end
			step_q.push_back(r);
		end else if (it.stream_byte == 8'h00) begin
			if (zeros_held < HELD_MAX)
				zeros_held = zeros_held + 2'd1;
			else
				put_payload(8'h00);
		end else if (it.stream_byte == START_BYTE && zeros_held == HELD_MAX) begin
			if (in_unit)
				close_unit();
			in_unit = 1'b1;
			unit_bytes = '0;
			first_type = '0;
			zeros_held = '0;
		end else begin
			while (zeros_held != 2'd0) begin
				put_payload(8'h00);
				zeros_held = zeros_held - 2'd1;
			end
			put_payload(it.stream_byte);
		end
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.last_of_run = 1'b1;
			step_q.push_back(r);
		end
	endtask

	task automatic build_plan();
		int pick;
		int n;
		int p;
		logic [5:0] t;
		logic [7:0] b;
		foreach (directed_rows[i])
			feed_q.push_back(directed_rows[i]);
		while (feed_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// start code, sometimes after extra zeros, then a unit with random content
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 5) : 3;
				repeat (n) add_byte(8'h00);
				add_byte(START_BYTE);
				if ($urandom_range(0, 9) != 0) begin
					if ($urandom_range(0, 3) != 0)
						t = $urandom_range(0, 1) ? 6'($urandom_range(0, 9)) :
							6'($urandom_range(16, 21));
					else
						t = 6'($urandom_range(0, 63));
					b = 8'($urandom);
					b[6:1] = t;
					add_byte(b);
					n = $urandom_range(0, 10);
					for (int k = 0; k < n; k++) begin
						p = $urandom_range(0, 9);
						if (p < 4)
							b = 8'h00;
						else if (p == 4)
							b = START_BYTE;
						else if (p == 5)
							b = 8'h03;
						else
							b = 8'($urandom);
						add_byte(b);
					end
				end
			end else if (pick < 74) begin
				add_tag();
			end else if (pick < 77) begin
				// enough tags to run the fifo full
				repeat ($urandom_range(17, 20)) add_tag();
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 6))
					add_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
			end else begin
				// broken start codes: too few zeros, or the wrong closing byte
				n = $urandom_range(1, 3);
				repeat (n) add_byte(8'h00);
				b = (n < 3) ? START_BYTE : 8'($urandom_range(2, 255));
				add_byte(b);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("mismatch on result %0d: %s got %0h want %0h",
				results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	initial begin : sender
		plan_row_t row;
		int burst_left;
		int gap_left;
		build_plan();
		burst_left = $urandom_range(1, 20);
		gap_left = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		forever begin
			@(posedge clk);
			if (item_valid && item_ready) begin
				row = feed_q.pop_front();
				deframe_request(row.stim);
				if (row.known)
					awaited_q.push_back(row.want);
				else
					foreach (step_q[i]) awaited_q.push_back(step_q[i]);
			end
			// a request not yet taken stays as it is
			if (item_valid && !item_ready)
				continue;
			if (feed_q.size() == 0) begin
				item_valid <= 1'b0;
				break;
			end
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else begin
				item_valid <= 1'b1;
				item <= feed_q[0].stim;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				end
			end
		end
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("annexb_nal_deframer_with_tag_fifo_unit_test: clean");
		else
			$display("annexb_nal_deframer_with_tag_fifo_unit_test: errors");
		$finish;
	end

	// receiver switches between always ready, random stalls and long stalls
	initial begin : receiver
		int mode;
		int mode_left;
		int stall_left;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				0: begin
					result_ready <= 1'b1;
				end
				1: begin
					result_ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						result_ready <= 1'b0;
					end else begin
						result_ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							stall_left = $urandom_range(2, 12);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_q.size() == 0) begin
				report_mismatch("result with nothing awaited", 64'(result), 64'd0);
			end else begin
				want = awaited_q.pop_front();
				check_field("result_kind", 64'(result.result_kind),
					64'(want.result_kind));
				check_field("payload_byte", 64'(result.payload_byte),
					64'(want.payload_byte));
				check_field("unit_length", 64'(result.unit_length),
					64'(want.unit_length));
				check_field("unit_type", 64'(result.unit_type),
					64'(want.unit_type));
				check_field("frame_tag_out", 64'(result.frame_tag_out),
					64'(want.frame_tag_out));
				check_field("tag_valid", 64'(result.tag_valid),
					64'(want.tag_valid));
				check_field("queue_error", 64'(result.queue_error),
					64'(want.queue_error));
				check_field("last_of_run", 64'(result.last_of_run),
					64'(want.last_of_run));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= CYCLE_LIMIT) begin
			$display("annexb_nal_deframer_with_tag_fifo_unit_test: errors");
			$finish;
		end
	end

endmodule
